// ===== sv/mp2d_pkg.sv =====
`default_nettype none

package mp2d_pkg;

    localparam int VAL_W       = 15;
    localparam int POOL_W      = 4;
    localparam int DIM_W       = 9;
    localparam int IDX_W       = 8;
    localparam int OFF_W       = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;

    localparam int DEF_MAX_OUT_WIDTH = 128;
    localparam int DEF_SAMPLE_BITS   = 16;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    localparam logic [POOL_W-1:0] POOL_MIN   = 4'd1;
    localparam logic [POOL_W-1:0] POOL_MAX   = 4'd8;
    localparam logic [POOL_W-1:0] POOL_RESET = 4'd2;

    localparam logic [DIM_W-1:0] DIM_MIN     = 9'd1;
    localparam logic [DIM_W-1:0] DIM_MAX     = 9'd256;
    localparam logic [DIM_W-1:0] WIDTH_RESET = 9'd32;
    localparam logic [DIM_W-1:0] COUNT_RESET = 9'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POOL_SIZE = 2'd0,
        REG_MAP_WIDTH = 2'd1,
        REG_MAP_COUNT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [POOL_W-1:0] pool;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  count;
    } geom_t;

    typedef struct packed {
        logic active;
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
        logic last_in_row;
        logic last_in_map;
        logic last_in_batch;
    } win_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/mp2d_in_if.sv =====
`default_nettype none

interface mp2d_in_if #(
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);

endinterface

`default_nettype wire

// ===== sv/mp2d_out_if.sv =====
`default_nettype none

interface mp2d_out_if;

    logic                        valid;
    logic                        ready;
    logic [mp2d_pkg::VAL_W-1:0]  pooled_value;
    logic                        last_in_row;
    logic                        last_in_map;
    logic                        last_in_batch;

    modport source (
        output valid,
        output pooled_value,
        output last_in_row,
        output last_in_map,
        output last_in_batch,
        input  ready
    );
    modport sink (
        input  valid,
        input  pooled_value,
        input  last_in_row,
        input  last_in_map,
        input  last_in_batch,
        output ready
    );

endinterface

`default_nettype wire

// ===== sv/mp2d_cfg.sv =====
`default_nettype none

module mp2d_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [mp2d_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mp2d_pkg::geom_t                  geom,
    output logic                             restart
);

    import mp2d_pkg::*;

    logic [POOL_W-1:0] pool_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  count_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v < DIM_MIN)
            r = DIM_MIN;
        else if (v > DIM_MAX)
            r = DIM_MAX;
        else
            r = v;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg  <= POOL_RESET;
            width_reg <= WIDTH_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_POOL_SIZE: pool_reg  <= cfg_data[POOL_W-1:0];
                REG_MAP_WIDTH: width_reg <= cfg_data[DIM_W-1:0];
                REG_MAP_COUNT: count_reg <= cfg_data[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_POOL_SIZE, REG_MAP_WIDTH, REG_MAP_COUNT: restart = cfg_wr_en;
            default:                                     restart = 1'b0;
        endcase
    end

    always_comb
    begin
        if (pool_reg < POOL_MIN)
            geom.pool = POOL_MIN;
        else if (pool_reg > POOL_MAX)
            geom.pool = POOL_MAX;
        else
            geom.pool = pool_reg;
        geom.width = clamp_dim(width_reg);
        geom.count = clamp_dim(count_reg);
    end

endmodule

`default_nettype wire

// ===== sv/mp2d_scan.sv =====
`default_nettype none

module mp2d_scan #(
    parameter int MAX_OUT_WIDTH = mp2d_pkg::DEF_MAX_OUT_WIDTH,
    parameter int LINE_AW       = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 restart,
    input  mp2d_pkg::geom_t      geom,
    output mp2d_pkg::win_ctrl_t  ctrl,
    output logic [LINE_AW-1:0]   line_addr
);

    import mp2d_pkg::*;

    localparam int SUM_W = DIM_W + 1;

    logic [IDX_W-1:0] col_reg, col_next;
    logic [OFF_W-1:0] off_col_reg, off_col_next;
    logic [DIM_W-1:0] wcol_reg, wcol_next;
    logic [DIM_W-1:0] col_base_reg, col_base_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [OFF_W-1:0] off_row_reg, off_row_next;
    logic [DIM_W-1:0] row_base_reg, row_base_next;
    logic [IDX_W-1:0] map_reg, map_next;

    logic [DIM_W-1:0]  col_inc;
    logic [DIM_W-1:0]  row_inc;
    logic [DIM_W-1:0]  map_inc;
    logic [POOL_W-1:0] off_col_inc;
    logic [POOL_W-1:0] off_row_inc;
    logic [POOL_W-1:0] pool_last;
    logic [SUM_W-1:0]  width_ext;
    logic [SUM_W-1:0]  pool_ext;
    logic [SUM_W-1:0]  pool_twice;
    logic              col_fit;
    logic              col_end;
    logic              row_fit;
    logic              row_end;
    logic              in_line;
    logic              wcol_at_max;

    assign col_inc     = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc     = DIM_W'(row_reg) + DIM_W'(1);
    assign map_inc     = DIM_W'(map_reg) + DIM_W'(1);
    assign off_col_inc = POOL_W'(off_col_reg) + POOL_W'(1);
    assign off_row_inc = POOL_W'(off_row_reg) + POOL_W'(1);
    assign pool_last   = geom.pool - POOL_W'(1);
    assign width_ext   = SUM_W'(geom.width);
    assign pool_ext    = SUM_W'(geom.pool);
    assign pool_twice  = SUM_W'({geom.pool, 1'b0});

    // window fits in the map, and is the last one that fits
    assign col_fit     = (SUM_W'(col_base_reg) + pool_ext) <= width_ext;
    assign col_end     = (SUM_W'(col_base_reg) + pool_twice) > width_ext;
    assign row_fit     = (SUM_W'(row_base_reg) + pool_ext) <= width_ext;
    assign row_end     = (SUM_W'(row_base_reg) + pool_twice) > width_ext;
    assign in_line     = wcol_reg < DIM_W'(MAX_OUT_WIDTH);
    assign wcol_at_max = wcol_reg == DIM_W'(MAX_OUT_WIDTH - 1);

    always_comb
    begin
        ctrl.active        = row_fit && col_fit && in_line;
        ctrl.first_col     = off_col_reg == '0;
        ctrl.last_col      = POOL_W'(off_col_reg) == pool_last;
        ctrl.first_row     = off_row_reg == '0;
        ctrl.last_row      = POOL_W'(off_row_reg) == pool_last;
        ctrl.last_in_row   = wcol_at_max || col_end;
        ctrl.last_in_map   = ctrl.last_in_row && row_end;
        ctrl.last_in_batch = ctrl.last_in_map && (map_inc == geom.count);
    end

    assign line_addr = wcol_reg[LINE_AW-1:0];

    always_comb
    begin
        col_next      = col_inc[IDX_W-1:0];
        off_col_next  = off_col_inc[OFF_W-1:0];
        wcol_next     = wcol_reg;
        col_base_next = col_base_reg;
        row_next      = row_reg;
        off_row_next  = off_row_reg;
        row_base_next = row_base_reg;
        map_next      = map_reg;
        if (off_col_inc >= geom.pool)
        begin
            off_col_next  = '0;
            wcol_next     = wcol_reg + DIM_W'(1);
            col_base_next = col_base_reg + DIM_W'(geom.pool);
        end
        if (col_inc >= geom.width)
        begin
            col_next      = '0;
            off_col_next  = '0;
            wcol_next     = '0;
            col_base_next = '0;
            row_next      = row_inc[IDX_W-1:0];
            if (off_row_inc >= geom.pool)
            begin
                off_row_next  = '0;
                row_base_next = row_base_reg + DIM_W'(geom.pool);
            end
            else
            begin
                off_row_next = off_row_inc[OFF_W-1:0];
            end
            if (row_inc >= geom.width)
            begin
                row_next      = '0;
                off_row_next  = '0;
                row_base_next = '0;
                if (map_inc >= geom.count)
                    map_next = '0;
                else
                    map_next = map_inc[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            off_col_reg  <= '0;
            wcol_reg     <= '0;
            col_base_reg <= '0;
            row_reg      <= '0;
            off_row_reg  <= '0;
            row_base_reg <= '0;
            map_reg      <= '0;
        end
        else if (restart)
        begin
            col_reg      <= '0;
            off_col_reg  <= '0;
            wcol_reg     <= '0;
            col_base_reg <= '0;
            row_reg      <= '0;
            off_row_reg  <= '0;
            row_base_reg <= '0;
            map_reg      <= '0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            off_col_reg  <= off_col_next;
            wcol_reg     <= wcol_next;
            col_base_reg <= col_base_next;
            row_reg      <= row_next;
            off_row_reg  <= off_row_next;
            row_base_reg <= row_base_next;
            map_reg      <= map_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        POOL_W'(off_col_reg) < geom.pool)
        else $error("column offset outside window");

    assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_reg) == col_base_reg + DIM_W'(off_col_reg))
        else $error("column base out of step with column index");

    assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(row_reg) == row_base_reg + DIM_W'(off_row_reg))
        else $error("row base out of step with row index");

endmodule

`default_nettype wire

// ===== sv/mp2d_line_ram.sv =====
`default_nettype none

module mp2d_line_ram #(
    parameter int MAX_OUT_WIDTH = mp2d_pkg::DEF_MAX_OUT_WIDTH,
    parameter int LINE_AW       = 7
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [LINE_AW-1:0]         rd_addr,
    output logic [mp2d_pkg::VAL_W-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [mp2d_pkg::VAL_W-1:0] wr_data
);

    import mp2d_pkg::*;

    logic [VAL_W-1:0]   mem [MAX_OUT_WIDTH];
    logic [VAL_W-1:0]   rd_data_reg;
    logic [LINE_AW-1:0] addr_reg;

    // write goes back to the entry read for the same item
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
        if (wr_en)
            mem[addr_reg] <= wr_data;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/mp2d_reduce.sv =====
`default_nettype none

module mp2d_reduce #(
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    mp2d_in_if.sink                    samples,
    mp2d_out_if.source                 results,
    input  mp2d_pkg::win_ctrl_t        ctrl_in,
    output logic                       accept,
    input  logic [mp2d_pkg::VAL_W-1:0] line_rd_data,
    output logic                       line_we,
    output logic [mp2d_pkg::VAL_W-1:0] line_wr_data
);

    import mp2d_pkg::*;

    localparam int MAG_W = (SAMPLE_BITS - 1 > VAL_W) ? SAMPLE_BITS - 1 : VAL_W;

    logic             s1_valid_reg, s1_valid_next;
    win_ctrl_t        s1_ctrl_reg;
    logic [VAL_W-1:0] s1_value_reg;
    logic [VAL_W-1:0] run_max_reg;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_row_reg;
    logic             out_map_reg;
    logic             out_batch_reg;

    logic [MAG_W-1:0] mag;
    logic [VAL_W-1:0] floored;
    logic             advance;
    logic             emit;
    logic [VAL_W-1:0] run_max_new;
    logic [VAL_W-1:0] combined;

    // negative samples count as zero, wide ones saturate
    assign mag = MAG_W'(samples.sample[SAMPLE_BITS-2:0]);

    always_comb
    begin
        if (samples.sample[SAMPLE_BITS-1])
            floored = '0;
        else if (mag > MAG_W'(VAL_MAX))
            floored = VAL_MAX;
        else
            floored = mag[VAL_W-1:0];
    end

    assign advance       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !s1_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        if (s1_ctrl_reg.first_col || (s1_value_reg > run_max_reg))
            run_max_new = s1_value_reg;
        else
            run_max_new = run_max_reg;
        if (!s1_ctrl_reg.first_row && (line_rd_data > run_max_new))
            combined = line_rd_data;
        else
            combined = run_max_new;
    end

    assign emit    = advance && s1_ctrl_reg.active && s1_ctrl_reg.last_col
                     && s1_ctrl_reg.last_row;
    assign line_we = advance && s1_ctrl_reg.active && s1_ctrl_reg.last_col
                     && !s1_ctrl_reg.last_row;
    assign line_wr_data = combined;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_max_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (restart)
                run_max_reg <= '0;
            else if (advance && s1_ctrl_reg.active)
                run_max_reg <= run_max_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg  <= ctrl_in;
            s1_value_reg <= floored;
        end
        if (emit)
        begin
            out_value_reg <= combined;
            out_row_reg   <= s1_ctrl_reg.last_in_row;
            out_map_reg   <= s1_ctrl_reg.last_in_map;
            out_batch_reg <= s1_ctrl_reg.last_in_batch;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.pooled_value  = out_value_reg;
    assign results.last_in_row   = out_row_reg;
    assign results.last_in_map   = out_map_reg;
    assign results.last_in_batch = out_batch_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> advance)
        else $error("item taken over a stalled stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_value_reg))
        else $error("stalled stage lost its item");

    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (!results.last_in_batch || results.last_in_map)
                          && (!results.last_in_map || results.last_in_row))
        else $error("end marks not nested");

endmodule

`default_nettype wire

// ===== sv/max_pool_2d_stream.sv =====
// an accepted item is registered in the compare stage, and its result then in the output register
// throughput: one item per cycle; input ready drops only while a result is
// stalled at the output and the next item is already in the compare stage
// reset: stream position, running maximum and valid flags cleared; registers
// take pool_size 2, map_width 32, map_count 1; the line store is not cleared
`default_nettype none

module max_pool_2d_stream #(
    parameter int MAX_OUT_WIDTH = mp2d_pkg::DEF_MAX_OUT_WIDTH,
    parameter int SAMPLE_BITS   = mp2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [mp2d_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    mp2d_in_if.sink                          samples,
    mp2d_out_if.source                       results
);

    import mp2d_pkg::*;

    localparam int LINE_AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    geom_t              geom;
    logic               restart;
    logic               accept;
    win_ctrl_t          ctrl;
    logic [LINE_AW-1:0] line_addr;
    logic [VAL_W-1:0]   line_rd_data;
    logic               line_we;
    logic [VAL_W-1:0]   line_wr_data;

    mp2d_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .restart   (restart)
    );

    mp2d_scan #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .LINE_AW       (LINE_AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .restart   (restart),
        .geom      (geom),
        .ctrl      (ctrl),
        .line_addr (line_addr)
    );

    mp2d_line_ram #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .LINE_AW       (LINE_AW)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (line_addr),
        .rd_data (line_rd_data),
        .wr_en   (line_we),
        .wr_data (line_wr_data)
    );

    mp2d_reduce #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_reduce (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .samples      (samples),
        .results      (results),
        .ctrl_in      (ctrl),
        .accept       (accept),
        .line_rd_data (line_rd_data),
        .line_we      (line_we),
        .line_wr_data (line_wr_data)
    );

endmodule

`default_nettype wire
